// ===== hw/rtl/dps_pkg.sv =====
`timescale 1ns / 1ps

package dps_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] OP_NONE    = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_REQUEUE = 2'd2;
  localparam logic [1:0] OP_FINISH  = 2'd3;

  typedef struct packed {
    logic       command;
    logic [3:0] slot;
    logic [7:0] load_priority;
    logic [7:0] load_time;
  } cmd_t;

  typedef struct packed {
    logic       picked;
    logic [3:0] picked_slot;
    logic [7:0] time_after;
    logic [7:0] priority_after;
    logic       done_now;
    logic       any_left;
  } res_t;

  typedef struct packed {
    logic             found;
    logic [7:0]       prio;
    logic [IDX_W-1:0] rank;
    logic [IDX_W-1:0] idx;
    logic [7:0]       slices;
  } token_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] target;
    logic [IDX_W-1:0] old_rank;
    logic [IDX_W-1:0] new_rank;
    logic [7:0]       prio;
    logic [7:0]       slices;
  } upd_t;

  function automatic logic [IDX_W-1:0] slot_to_index(input logic [3:0] s);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int v = 0; v < 16; v++) begin
      if (s == 4'(v)) begin
        r = IDX_W'(v % ENTRIES);
      end
    end
    return r;
  endfunction

  function automatic logic [3:0] index_to_slot(input logic [IDX_W-1:0] i);
    logic [31:0] w;
    w = 32'(i);
    return w[3:0];
  endfunction

endpackage

// ===== hw/rtl/dps_cell.sv =====
`timescale 1ns / 1ps

module dps_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [dps_pkg::IDX_W-1:0] my_index,
  input  dps_pkg::token_t       tok_in,
  output dps_pkg::token_t       tok_out,
  input  dps_pkg::upd_t         upd,
  output logic                  runnable
);
  import dps_pkg::*;

  logic [7:0]       prio;
  logic [7:0]       slices;
  logic             finished;
  logic [IDX_W-1:0] rank;
  logic             take;
  logic             hit;

  assign runnable = (prio != 8'd0) && !finished;
  assign hit      = (upd.target == my_index);
  assign take     = runnable && (!tok_in.found || (prio > tok_in.prio) ||
                    ((prio == tok_in.prio) && (rank < tok_in.rank)));

  always_ff @(posedge clk) begin
    if (take) begin
      tok_out <= '{found: 1'b1, prio: prio, rank: rank, idx: my_index, slices: slices};
    end else begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prio     <= '0;
      slices   <= '0;
      finished <= 1'b0;
      rank     <= '0;
    end else begin
      unique case (upd.op)
        OP_LOAD: begin
          if (hit) begin
            prio     <= upd.prio;
            slices   <= upd.slices;
            finished <= 1'b0;
            rank     <= upd.new_rank;
          end
        end
        OP_REQUEUE: begin
          if (hit) begin
            prio   <= prio - 8'd1;
            slices <= slices - 8'd1;
            rank   <= upd.new_rank;
          end else if (rank > upd.old_rank) begin
            rank <= rank - 1'b1;
          end
        end
        OP_FINISH: begin
          if (hit) begin
            slices   <= 8'd0;
            finished <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/dynamic_priority_scheduler_core.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// cmd      in         cmd_valid / cmd_stall  cmd (load or tick)
// res      out        res_valid / res_stall  res (one per transaction)
//
// A load goes from acceptance straight to its update and report; a tick first scans,
// with the best-candidate token walking the row of entry cells one per cycle.
// One transaction is in flight at a time; the next is accepted as soon as the
// result sits in the output register, even while res_stall holds it there.
// Synchronous reset clears every entry, the queue count and both handshakes.

module dynamic_priority_scheduler_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  dps_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output dps_pkg::res_t res
);
  import dps_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_REPORT = 2'd3;

  logic [1:0]       state;
  logic [IDX_W-1:0] scan_count;
  cmd_t             item;
  logic [CNT_W-1:0] loaded_count;
  logic [CNT_W-1:0] count_less;
  res_t             pend;
  res_t             pend_next;
  res_t             res_next;
  upd_t             upd;
  token_t           tok [0:ENTRIES];
  token_t           best;
  logic [ENTRIES-1:0] runnable;
  logic             out_free;
  logic             requeue;

  assign tok[0]     = '0;
  assign best       = tok[ENTRIES];
  assign cmd_stall  = (state != ST_IDLE);
  assign out_free   = !res_valid || !res_stall;
  assign count_less = loaded_count - 1'b1;
  assign requeue    = (best.slices > 8'd1);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    dps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .my_index (IDX_W'(i)),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .upd      (upd),
      .runnable (runnable[i])
    );
  end

  always_comb begin
    upd       = '0;
    upd.op    = OP_NONE;
    pend_next = '0;
    if (state == ST_UPDATE) begin
      if (item.command == CMD_LOAD) begin
        upd.op     = OP_LOAD;
        upd.target = slot_to_index(item.slot);
        upd.prio   = item.load_priority;
        upd.slices = item.load_time;
        upd.new_rank = (loaded_count < CNT_W'(ENTRIES)) ? loaded_count[IDX_W-1:0]
                                                        : IDX_W'(ENTRIES - 1);
      end else if (best.found) begin
        upd.target               = best.idx;
        upd.old_rank             = best.rank;
        upd.new_rank             = (loaded_count == '0) ? '0 : count_less[IDX_W-1:0];
        pend_next.picked         = 1'b1;
        pend_next.picked_slot    = index_to_slot(best.idx);
        if (requeue) begin
          upd.op                   = OP_REQUEUE;
          pend_next.time_after     = best.slices - 8'd1;
          pend_next.priority_after = best.prio - 8'd1;
        end else begin
          upd.op                   = OP_FINISH;
          pend_next.priority_after = best.prio;
          pend_next.done_now       = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_next          = pend;
    res_next.any_left = |runnable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      scan_count   <= '0;
      loaded_count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            item       <= cmd;
            scan_count <= '0;
            state      <= (cmd.command == CMD_TICK) ? ST_SCAN : ST_UPDATE;
          end
        end
        ST_SCAN: begin
          scan_count <= scan_count + 1'b1;
          if (scan_count == IDX_W'(ENTRIES - 1)) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          pend  <= pend_next;
          state <= ST_REPORT;
          if ((item.command == CMD_LOAD) && (loaded_count < CNT_W'(ENTRIES))) begin
            loaded_count <= loaded_count + 1'b1;
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == ST_REPORT) && out_free) begin
      res       <= res_next;
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/dps_checker.sv =====
`timescale 1ns / 1ps

module dps_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input dps_pkg::cmd_t cmd,
  input logic          res_valid,
  input logic          res_stall,
  input dps_pkg::res_t res
);
  import dps_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("Stalled result changed or dropped.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("Command channel did not stall after a transaction.");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.picked |-> res.picked_slot == 4'd0 && res.time_after == 8'd0 &&
      res.priority_after == 8'd0 && !res.done_now)
    else $error("Result without a pick carries nonzero fields.");

  a_done_time: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.picked |-> (res.done_now == (res.time_after == 8'd0)))
    else $error("Finish mark disagrees with remaining slices.");

endmodule

bind dynamic_priority_scheduler_core dps_checker u_dps_checker (.*);

// ===== dv/dynamic_priority_scheduler_core_tb.sv =====
`timescale 1ns / 1ps

module dynamic_priority_scheduler_core_tb;
  import dps_pkg::*;

  class schedule_book;
    logic [7:0]       prio_of     [ENTRIES];
    logic [7:0]       slices_of   [ENTRIES];
    logic             finished_of [ENTRIES];
    logic [IDX_W-1:0] rank_of     [ENTRIES];
    logic [CNT_W-1:0] load_count;
    res_t             expected_results[$];
    int               mismatches;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        prio_of[i] = '0;
        slices_of[i] = '0;
        finished_of[i] = 1'b0;
        rank_of[i] = '0;
      end
      load_count = '0;
      mismatches = 0;
    endfunction

    function bit runnable(int i);
      return prio_of[i] != 8'd0 && !finished_of[i];
    endfunction

    function void take_command(cmd_t c);
      res_t             r;
      int               idx;
      int               best;
      bit               found;
      logic [IDX_W-1:0] old_rank;
      r = '0;
      idx = int'(c.slot) % ENTRIES;
      if (c.command == CMD_LOAD) begin
        prio_of[idx] = c.load_priority;
        slices_of[idx] = c.load_time;
        finished_of[idx] = 1'b0;
        if (load_count < ENTRIES) begin
          rank_of[idx] = IDX_W'(load_count);
          load_count = load_count + 1'b1;
        end else begin
          rank_of[idx] = IDX_W'(ENTRIES - 1);
        end
      end else begin
        found = 1'b0;
        best = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (runnable(i)) begin
            if (!found || prio_of[i] > prio_of[best] ||
                (prio_of[i] == prio_of[best] && rank_of[i] < rank_of[best])) begin
              best = i;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          if (slices_of[best] > 8'd1) begin
            old_rank = rank_of[best];
            slices_of[best] = slices_of[best] - 1'b1;
            prio_of[best] = prio_of[best] - 1'b1;
            for (int i = 0; i < ENTRIES; i++) begin
              if (i != best && rank_of[i] > old_rank) begin
                rank_of[i] = rank_of[i] - 1'b1;
              end
            end
            rank_of[best] = (load_count == '0) ? '0 : IDX_W'(load_count - 1'b1);
            r.done_now = 1'b0;
          end else begin
            slices_of[best] = 8'd0;
            finished_of[best] = 1'b1;
            r.done_now = 1'b1;
          end
          r.picked = 1'b1;
          r.picked_slot = 4'(best);
          r.time_after = slices_of[best];
          r.priority_after = prio_of[best];
        end
      end
      r.any_left = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (runnable(i)) begin
          r.any_left = 1'b1;
        end
      end
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        $error("result transaction with no expectation pending: %p", got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("picked", 8'(want.picked), 8'(got.picked));
      compare_field("picked_slot", 8'(want.picked_slot), 8'(got.picked_slot));
      compare_field("time_after", want.time_after, got.time_after);
      compare_field("priority_after", want.priority_after, got.priority_after);
      compare_field("done_now", 8'(want.done_now), 8'(got.done_now));
      compare_field("any_left", 8'(want.any_left), 8'(got.any_left));
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  schedule_book book = new();
  int idle_pct = 0;
  int stall_pct = 0;
  bit want_hold = 1'b0;

  dynamic_priority_scheduler_core uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic cmd_t make_cmd(logic op, int s, int p, int t);
    cmd_t c;
    c.command = op;
    c.slot = 4'(s);
    c.load_priority = 8'(p);
    c.load_time = 8'(t);
    return c;
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    c.command = ($urandom_range(99) < 45) ? CMD_LOAD : CMD_TICK;
    c.slot = 4'($urandom_range(15));
    case ($urandom_range(9))
      0: c.load_priority = 8'd0;
      1, 2: c.load_priority = 8'($urandom_range(255));
      default: c.load_priority = 8'($urandom_range(1, 6));
    endcase
    case ($urandom_range(9))
      0: c.load_time = 8'd0;
      1: c.load_time = 8'($urandom_range(255));
      default: c.load_time = 8'($urandom_range(1, 8));
    endcase
    return c;
  endfunction

  task automatic send_command(input cmd_t c);
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    book.take_command(c);
    if ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  initial begin
    int hold_count;
    hold_count = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        book.check_result(res);
      end
      if (want_hold && hold_count == 0) begin
        hold_count = 300;
        want_hold = 1'b0;
      end
      if (hold_count > 0) begin
        hold_count--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    int idle_setting[4];
    int stall_setting[4];
    idle_setting = '{0, 56, 0, 36};
    stall_setting = '{0, 0, 56, 36};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_command(make_cmd(CMD_TICK, 0, 0, 0));
    send_command(make_cmd(CMD_LOAD, 0, 0, 5));
    send_command(make_cmd(CMD_TICK, 0, 0, 0));
    send_command(make_cmd(CMD_LOAD, 15, 255, 255));
    send_command(make_cmd(CMD_LOAD, 7, 255, 2));
    send_command(make_cmd(CMD_TICK, 15, 255, 255));
    send_command(make_cmd(CMD_TICK, 0, 0, 0));
    send_command(make_cmd(CMD_TICK, 0, 0, 0));
    send_command(make_cmd(CMD_LOAD, 15, 0, 0));
    send_command(make_cmd(CMD_TICK, 0, 0, 0));
    send_command(make_cmd(CMD_LOAD, 3, 1, 1));
    send_command(make_cmd(CMD_LOAD, 9, 1, 5));
    send_command(make_cmd(CMD_TICK, 0, 0, 0));
    send_command(make_cmd(CMD_TICK, 0, 0, 0));
    send_command(make_cmd(CMD_TICK, 0, 0, 0));
    send_command(make_cmd(CMD_LOAD, 12, 128, 0));
    send_command(make_cmd(CMD_TICK, 0, 0, 0));
    send_command(make_cmd(CMD_LOAD, 7, 200, 3));
    send_command(make_cmd(CMD_TICK, 0, 0, 0));
    send_command(make_cmd(CMD_TICK, 0, 0, 0));
    send_command(make_cmd(CMD_TICK, 0, 0, 0));
    send_command(make_cmd(CMD_LOAD, 5, 255, 1));
    send_command(make_cmd(CMD_TICK, 0, 0, 0));

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = idle_setting[phase];
      stall_pct = stall_setting[phase];
      for (int n = 0; n < 100; n++) begin
        if (phase == 0 && n == 20) begin
          want_hold = 1'b1;
        end
        send_command(random_command());
      end
    end

    cmd_valid <= 1'b0;
    stall_pct = 0;
    while (book.expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dps_pkg.sv
hw/rtl/dps_cell.sv
hw/rtl/dynamic_priority_scheduler_core.sv
hw/rtl/dps_checker.sv
dv/dynamic_priority_scheduler_core_tb.sv
